### design/ltgov_pkg.sv
// Shared widths, limits and register codes for the load tier governor.
package ltgov_pkg;

  localparam int TIME_W  = 16;  // frame time, tenths of ms
  localparam int TIER_W  = 2;
  localparam int CFG_W   = 10;  // widest configuration register
  localparam int BSUM_W  = 26;
  localparam int BCNT_W  = 10;
  localparam int PROD_W  = CFG_W + BCNT_W;
  localparam int CIDX_W  = 2;

  localparam int TIER_MAX       = 2;
  localparam int HIST_DEPTH_DEF = 4;
  localparam int DWELL_DEF      = 8;

  localparam int HI_MIN   = 10;
  localparam int HI_MAX   = 1000;
  localparam int LO_MIN   = 5;
  localparam int NBLK_MIN = 1;
  localparam int NBLK_MAX = 600;

  localparam int HI_RST   = 150;
  localparam int LO_RST   = 120;
  localparam int NBLK_RST = 30;

  typedef enum logic [CIDX_W-1:0] {
    CFG_AUTO_ENABLE  = 2'd0,
    CFG_HIGH_THRESH  = 2'd1,
    CFG_LOW_THRESH   = 2'd2,
    CFG_BLOCK_FRAMES = 2'd3
  } cfg_idx_t;

endpackage

### design/ltgov_in_if.sv
// Input channel: one frame time and floor level per word.
interface ltgov_in_if;
  import ltgov_pkg::*;
  logic              valid;
  logic              ready;
  logic [TIME_W-1:0] frame_time;
  logic [TIER_W-1:0] floor_level;

  modport source(output valid, frame_time, floor_level, input ready);
  modport sink(input valid, frame_time, floor_level, output ready);
endinterface

### design/ltgov_out_if.sv
// Result channel: effective level, tier and change flags per word.
interface ltgov_out_if;
  import ltgov_pkg::*;
  logic              valid;
  logic              ready;
  logic [TIER_W-1:0] effective_level;
  logic [TIER_W-1:0] current_tier;
  logic              raised;
  logic              lowered;

  modport source(output valid, effective_level, current_tier, raised, lowered, input ready);
  modport sink(input valid, effective_level, current_tier, raised, lowered, output ready);
endinterface

### design/ltgov_history.sv
// Ring of recent frame times with a running sum and the raise threshold test.
module ltgov_history #(
  parameter int HIST_DEPTH = ltgov_pkg::HIST_DEPTH_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        wr_en,
  input  logic                        clr_fill,
  input  logic [ltgov_pkg::TIME_W-1:0] frame_time,
  input  logic [ltgov_pkg::CFG_W-1:0]  hi_thr,
  output logic                        ring_high
);
  import ltgov_pkg::*;

  localparam int POS_W  = $clog2(HIST_DEPTH);
  localparam int FILL_W = $clog2(HIST_DEPTH + 1);
  localparam int RSUM_W = TIME_W + $clog2(HIST_DEPTH);

  logic [TIME_W-1:0] ring_r [HIST_DEPTH];
  logic [POS_W-1:0]  pos_r, pos_nxt;
  logic [FILL_W-1:0] fill_r, fill_nxt;
  logic [RSUM_W-1:0] sum_r, sum_nxt;
  logic [TIME_W-1:0] old_time;
  logic [RSUM_W-1:0] t_ext;
  logic [RSUM_W-1:0] thr;
  logic              full;

  assign old_time = ring_r[pos_r];
  assign t_ext    = RSUM_W'(frame_time);
  assign full     = (fill_r == FILL_W'(HIST_DEPTH));

  always_comb begin
    pos_nxt  = pos_r;
    fill_nxt = fill_r;
    sum_nxt  = sum_r;
    if (clr_fill) begin
      fill_nxt = '0;
    end else if (wr_en) begin
      pos_nxt = (pos_r == POS_W'(HIST_DEPTH - 1)) ? '0 : pos_r + POS_W'(1);
      if (!full) fill_nxt = fill_r + FILL_W'(1);
      // after a fill clear the next writes cover every entry once, so restart the sum
      if (fill_r == '0)  sum_nxt = t_ext;
      else if (full)     sum_nxt = sum_r - RSUM_W'(old_time) + t_ext;
      else               sum_nxt = sum_r + t_ext;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r  <= '0;
      fill_r <= '0;
    end else begin
      pos_r  <= pos_nxt;
      fill_r <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    sum_r <= sum_nxt;
    if (wr_en && !clr_fill) ring_r[pos_r] <= frame_time;
  end

  // truncated sum / depth > hi is the same as sum >= (hi + 1) * depth
  assign thr       = (RSUM_W'(hi_thr) + RSUM_W'(1)) * RSUM_W'(HIST_DEPTH);
  assign ring_high = full && (sum_r >= thr);

endmodule

### design/ltgov_sermul.sv
// Bit-serial shift-add multiplier: one multiplier bit per cycle.
module ltgov_sermul (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic [ltgov_pkg::CFG_W-1:0]  mcand,
  input  logic [ltgov_pkg::BCNT_W-1:0] mplier,
  output logic                         done,
  output logic [ltgov_pkg::PROD_W-1:0] product
);
  import ltgov_pkg::*;

  localparam int STEP_W = $clog2(BCNT_W + 1);

  logic              run_r, run_nxt;
  logic              done_r, done_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic [PROD_W-1:0] mc_r, mc_nxt;
  logic [BCNT_W-1:0] mp_r, mp_nxt;
  logic [PROD_W-1:0] acc_r, acc_nxt;

  always_comb begin
    run_nxt  = run_r;
    done_nxt = 1'b0;
    step_nxt = step_r;
    mc_nxt   = mc_r;
    mp_nxt   = mp_r;
    acc_nxt  = acc_r;
    if (start) begin
      run_nxt  = 1'b1;
      step_nxt = STEP_W'(BCNT_W);
      mc_nxt   = PROD_W'(mcand);
      mp_nxt   = mplier;
      acc_nxt  = '0;
    end else if (run_r) begin
      if (mp_r[0]) acc_nxt = acc_r + mc_r;
      mc_nxt   = mc_r << 1;
      mp_nxt   = mp_r >> 1;
      step_nxt = step_r - STEP_W'(1);
      if (step_r == STEP_W'(1)) begin
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      run_r  <= run_nxt;
      done_r <= done_nxt;
      step_r <= step_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mc_r  <= mc_nxt;
    mp_r  <= mp_nxt;
    acc_r <= acc_nxt;
  end

  assign done    = done_r;
  assign product = acc_r;

endmodule

### design/load_tier_governor_core.sv
// Load tier governor top level: sequencer, block accumulator, tier state and result register.
//
// A frame word passes these steps from acceptance to a loaded result: accept it, update the
// ring, dwell counter and block accumulator, run the bit-serial multiply of the low threshold
// by the block count (one count bit per cycle, then a completion flag) that decides the
// block-average test without a divider, decide the tier change and load the output register.
// With automatic mode off a word skips the multiply and the decision. in_ch.ready is high only
// while the sequencer is idle; a result waiting in the output register does not block the
// next word until that word's own result is due. Configuration writes land at once and must
// only be made while the block is idle. Reset leaves the governor in automatic mode with
// thresholds 150 and 120 and a 30-frame block.
module load_tier_governor_core #(
  parameter int HIST_DEPTH   = ltgov_pkg::HIST_DEPTH_DEF,
  parameter int DWELL_FRAMES = ltgov_pkg::DWELL_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  ltgov_in_if.sink                     in_ch,
  ltgov_out_if.source                  out_ch,
  input  logic                         cfg_we,
  input  logic [ltgov_pkg::CIDX_W-1:0] cfg_index,
  input  logic [ltgov_pkg::CFG_W-1:0]  cfg_wdata
);
  import ltgov_pkg::*;

  localparam int FSC_W = $clog2(DWELL_FRAMES + 1);

  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_UPDATE = 5'b00010,
    ST_MUL    = 5'b00100,
    ST_DECIDE = 5'b01000,
    ST_OUT    = 5'b10000
  } state_t;

  typedef struct packed {
    logic [TIER_W-1:0] eff;
    logic [TIER_W-1:0] tier;
    logic              raised;
    logic              lowered;
  } res_t;

  // configuration
  logic             auto_en_r;
  logic [CFG_W-1:0] hi_thr_r, lo_thr_r, blk_frames_r;
  logic [CFG_W-1:0] hi_c, lo_c, nblk_c;

  // sequencer and item state
  state_t            state_r, state_nxt;
  logic [TIME_W-1:0] t_r;
  logic [TIER_W-1:0] floor_r, floor_in;
  logic [TIER_W-1:0] tier_r, tier_nxt;
  logic [FSC_W-1:0]  fsc_r, fsc_nxt;
  logic [BSUM_W-1:0] bsum_r, bsum_nxt;
  logic [BCNT_W-1:0] bcnt_r, bcnt_nxt, bcnt_inc;
  logic              blk_done_r, blk_done_nxt;
  res_t              res_r, res_nxt;
  logic              ovalid_r, ovalid_nxt;
  res_t              ores_r, ores_nxt;

  logic              in_acc, out_free;
  logic              hist_wr, hist_clr, ring_high;
  logic              mul_start, mul_done;
  logic [PROD_W-1:0] prod;
  logic [TIER_W-1:0] cur, cur_up, cur_dn;
  logic              blk_low, do_raise, do_lower;

  assign in_acc   = in_ch.valid && in_ch.ready;
  assign out_free = !ovalid_r || out_ch.ready;
  assign floor_in = (in_ch.floor_level > TIER_W'(TIER_MAX)) ? TIER_W'(TIER_MAX)
                                                             : in_ch.floor_level;
  assign bcnt_inc = bcnt_r + BCNT_W'(1);

  // clamp the registers where they are used
  always_comb begin
    if (hi_thr_r < CFG_W'(HI_MIN))      hi_c = CFG_W'(HI_MIN);
    else if (hi_thr_r > CFG_W'(HI_MAX)) hi_c = CFG_W'(HI_MAX);
    else                                hi_c = hi_thr_r;
    if (lo_thr_r < CFG_W'(LO_MIN)) lo_c = CFG_W'(LO_MIN);
    else if (lo_thr_r > hi_c)      lo_c = hi_c;
    else                           lo_c = lo_thr_r;
    if (blk_frames_r < CFG_W'(NBLK_MIN))      nblk_c = CFG_W'(NBLK_MIN);
    else if (blk_frames_r > CFG_W'(NBLK_MAX)) nblk_c = CFG_W'(NBLK_MAX);
    else                                      nblk_c = blk_frames_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      auto_en_r    <= 1'b1;
      hi_thr_r     <= CFG_W'(HI_RST);
      lo_thr_r     <= CFG_W'(LO_RST);
      blk_frames_r <= CFG_W'(NBLK_RST);
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_AUTO_ENABLE:  auto_en_r    <= cfg_wdata[0];
        CFG_HIGH_THRESH:  hi_thr_r     <= cfg_wdata;
        CFG_LOW_THRESH:   lo_thr_r     <= cfg_wdata;
        CFG_BLOCK_FRAMES: blk_frames_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  ltgov_history #(
    .HIST_DEPTH(HIST_DEPTH)
  ) u_hist (
    .clk       (clk),
    .rst_n     (rst_n),
    .wr_en     (hist_wr),
    .clr_fill  (hist_clr),
    .frame_time(t_r),
    .hi_thr    (hi_c),
    .ring_high (ring_high)
  );

  // block average below lo is the same as block sum < lo * count
  ltgov_sermul u_mul (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (mul_start),
    .mcand  (lo_c),
    .mplier (bcnt_inc),
    .done   (mul_done),
    .product(prod)
  );

  // tier decision
  assign cur      = (tier_r < floor_r) ? floor_r : tier_r;
  assign cur_up   = cur + TIER_W'(1);
  assign cur_dn   = cur - TIER_W'(1);
  assign blk_low  = blk_done_r && (bsum_r < BSUM_W'(prod));
  assign do_raise = ring_high && (fsc_r == FSC_W'(DWELL_FRAMES)) && (cur < TIER_W'(TIER_MAX));
  assign do_lower = !do_raise && blk_low && (cur > floor_r);

  always_comb begin
    state_nxt    = state_r;
    tier_nxt     = tier_r;
    fsc_nxt      = fsc_r;
    bsum_nxt     = bsum_r;
    bcnt_nxt     = bcnt_r;
    blk_done_nxt = blk_done_r;
    res_nxt      = res_r;
    hist_wr      = 1'b0;
    hist_clr     = 1'b0;
    mul_start    = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) state_nxt = ST_UPDATE;
      end
      ST_UPDATE: begin
        if (!auto_en_r) begin
          tier_nxt  = '0;
          hist_clr  = 1'b1;
          bsum_nxt  = '0;
          bcnt_nxt  = '0;
          res_nxt   = '{eff: floor_r, tier: '0, raised: 1'b0, lowered: 1'b0};
          state_nxt = ST_OUT;
        end else begin
          hist_wr = 1'b1;
          if (fsc_r != FSC_W'(DWELL_FRAMES)) fsc_nxt = fsc_r + FSC_W'(1);
          bsum_nxt     = bsum_r + BSUM_W'(t_r);
          bcnt_nxt     = bcnt_inc;
          blk_done_nxt = (bcnt_inc >= BCNT_W'(nblk_c));
          mul_start    = 1'b1;
          state_nxt    = ST_MUL;
        end
      end
      ST_MUL: begin
        if (mul_done) state_nxt = ST_DECIDE;
      end
      ST_DECIDE: begin
        tier_nxt = cur;
        if (blk_done_r) begin
          bsum_nxt = '0;
          bcnt_nxt = '0;
        end
        if (do_raise) begin
          tier_nxt = cur_up;
          fsc_nxt  = '0;
          bsum_nxt = '0;
          bcnt_nxt = '0;
        end else if (do_lower) begin
          tier_nxt = cur_dn;
          fsc_nxt  = '0;
        end
        res_nxt.tier    = tier_nxt;
        res_nxt.eff     = (tier_nxt > floor_r) ? tier_nxt : floor_r;
        res_nxt.raised  = do_raise;
        res_nxt.lowered = do_lower;
        state_nxt       = ST_OUT;
      end
      ST_OUT: begin
        if (out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // output register: drain on ready, load when the sequencer hands over a word
  always_comb begin
    ovalid_nxt = ovalid_r;
    ores_nxt   = ores_r;
    if (ovalid_r && out_ch.ready) ovalid_nxt = 1'b0;
    if (state_r == ST_OUT && out_free) begin
      ovalid_nxt = 1'b1;
      ores_nxt   = res_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      tier_r   <= '0;
      fsc_r    <= FSC_W'(DWELL_FRAMES);
      bsum_r   <= '0;
      bcnt_r   <= '0;
      ovalid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      tier_r   <= tier_nxt;
      fsc_r    <= fsc_nxt;
      bsum_r   <= bsum_nxt;
      bcnt_r   <= bcnt_nxt;
      ovalid_r <= ovalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      t_r     <= in_ch.frame_time;
      floor_r <= floor_in;
    end
    blk_done_r <= blk_done_nxt;
    res_r      <= res_nxt;
    ores_r     <= ores_nxt;
  end

  assign in_ch.ready            = (state_r == ST_IDLE);
  assign out_ch.valid           = ovalid_r;
  assign out_ch.effective_level = ores_r.eff;
  assign out_ch.current_tier    = ores_r.tier;
  assign out_ch.raised          = ores_r.raised;
  assign out_ch.lowered         = ores_r.lowered;

  a_no_raise_and_lower: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> !(out_ch.raised && out_ch.lowered))
    else $error("raise and lower reported on one word");

  a_mul_done_in_mul: assert property (@(posedge clk) disable iff (!rst_n)
    mul_done |-> state_r == ST_MUL)
    else $error("multiplier finished outside the multiply state");

  a_block_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    bcnt_r <= BCNT_W'(NBLK_MAX))
    else $error("block count ran past the longest block");

  a_tier_above_floor: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_DECIDE |=> tier_r >= floor_r)
    else $error("tier fell below the floor after a decision");

endmodule
